>>> src/kpl_pkg.sv
`timescale 1ns / 1ps
// Shared types, key codes and defaults for the keypad lock controller.
package kpl_pkg;

    localparam int CODE_LEN_DEF  = 6;
    localparam int NUM_SLOTS_DEF = 10;
    localparam int DIGIT_W       = 4;
    localparam int TICKS_W       = 8;

    localparam logic [TICKS_W-1:0] TIMEOUT_RST = 8'd23;

    localparam logic [DIGIT_W-1:0] BLANK      = 4'd15;
    localparam logic [DIGIT_W-1:0] KEY_CLEAR  = 4'd10;
    localparam logic [DIGIT_W-1:0] KEY_ENTER  = 4'd11;
    localparam logic [DIGIT_W-1:0] KEY_PROGEN = 4'd12;

    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [2:0] {
        SESS_IDLE     = 3'd0,
        SESS_PASS     = 3'd1,
        SESS_ADMCHK   = 3'd2,
        SESS_NEWADM   = 3'd3,
        SESS_ADMRPT   = 3'd4,
        SESS_SLOTSEL  = 3'd5,
        SESS_CLRCONF  = 3'd6,
        SESS_SLOTCODE = 3'd7
    } sess_t;

    typedef enum logic [1:0] {
        CS_WAIT   = 2'd0,
        CS_SCAN   = 2'd1,
        CS_COMMIT = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
    } ctrl_sts_t;

endpackage

>>> src/kpl_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the keypad lock: accept, slot scan, commit under output handshake.
module kpl_ctrl
    import kpl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_WAIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_ready       = 1'b0;
        m_valid_next  = m_ready ? 1'b0 : m_valid_reg;
        unique case (state_reg)
            CS_WAIT: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = CS_SCAN;
                end
            end
            CS_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = CS_COMMIT;
                end
            end
            CS_COMMIT: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = CS_WAIT;
                end
            end
            default: begin
                state_next = CS_WAIT;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("result committed over an untaken word");

    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == CS_SCAN))
        else $error("accepted word did not start a scan");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.commit))
        else $error("result valid raised without a commit");
`endif

endmodule

>>> src/kpl_dp.sv
`timescale 1ns / 1ps
// Datapath: session state, entry buffers, admin code, passcode slots, result register.
module kpl_dp
    import kpl_pkg::*;
#(
    parameter int CODE_LEN  = CODE_LEN_DEF,
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [TICKS_W-1:0] cfg_wr_data,
    input  logic               s_mode,
    input  logic [DIGIT_W-1:0] s_key,
    input  ctrl_cmd_t          cmd,
    output ctrl_sts_t          sts,
    output logic               m_unlock,
    output logic [2:0]         m_session_state,
    output logic               m_code_written,
    output logic               m_timed_out
);

    localparam int CODE_W = DIGIT_W * CODE_LEN;
    localparam int CNT_W  = $clog2(CODE_LEN + 2);
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_LEN);

    // latched input word
    logic               mode_reg;
    logic [DIGIT_W-1:0] key_reg;

    // slot scan
    logic [SLOT_W-1:0]  scan_idx_reg;
    logic               match_reg;
    logic [CODE_W-1:0]  slot_rd;

    // session state
    sess_t              sess_reg, sess_next;
    logic [CODE_W-1:0]  ent_reg, ent_next;
    logic [CODE_W-1:0]  rpt_reg, rpt_next;
    logic [CNT_W-1:0]   ecnt_reg, ecnt_next;
    logic [CNT_W-1:0]   rcnt_reg, rcnt_next;
    logic [DIGIT_W-1:0] slot_reg, slot_next;
    logic [CODE_W-1:0]  admin_reg, admin_next;
    logic [TICKS_W-1:0] cd_reg, cd_next;
    logic [TICKS_W-1:0] timeout_reg;

    // passcode slots; a slot without its set bit reads as its default
    logic [CODE_W-1:0]    slot_code_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] slot_set_reg;

    logic [CODE_W-1:0]  admin_def;
    logic               unlock, written, timed;
    logic               rst, clr, def_all, slot_wr, slot_def;
    logic               is_key, is_clr, is_ent, is_prog;

    always_comb begin
        for (int i = 0; i < CODE_LEN; i++) begin
            admin_def[DIGIT_W*i +: DIGIT_W] = DIGIT_W'(i % 10);
        end
    end

    assign slot_rd = slot_set_reg[scan_idx_reg] ? slot_code_mem[scan_idx_reg]
                                                : {CODE_LEN{DIGIT_W'(scan_idx_reg)}};
    assign sts.scan_last = (scan_idx_reg == SLOT_W'(NUM_SLOTS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg <= s_mode;
            key_reg  <= s_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            match_reg    <= 1'b0;
        end else if (cmd.accept) begin
            scan_idx_reg <= '0;
            match_reg    <= 1'b0;
        end else if (cmd.scan_step) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            match_reg    <= match_reg || (ent_reg == slot_rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // one step of the session machine, applied at commit
    always_comb begin
        sess_next  = sess_reg;
        ent_next   = ent_reg;
        rpt_next   = rpt_reg;
        ecnt_next  = ecnt_reg;
        rcnt_next  = rcnt_reg;
        slot_next  = slot_reg;
        admin_next = admin_reg;
        cd_next    = cd_reg;
        unlock     = 1'b0;
        written    = 1'b0;
        timed      = 1'b0;
        rst        = 1'b0;
        clr        = 1'b0;
        def_all    = 1'b0;
        slot_wr    = 1'b0;
        slot_def   = 1'b0;
        is_key     = (mode_reg != MODE_TICK) && (key_reg <= KEY_PROGEN);
        is_clr     = (key_reg == KEY_CLEAR);
        is_ent     = (key_reg == KEY_ENTER);
        is_prog    = is_key && (key_reg == KEY_PROGEN);

        if (mode_reg == MODE_TICK) begin
            if (cd_reg > 8'd1) begin
                cd_next = cd_reg - 1'b1;
            end else if (cd_reg == 8'd1) begin
                rst   = 1'b1;
                timed = 1'b1;
            end
        end else if (is_prog) begin
            // PROGEN restarts the session in admin check; from idle the countdown is loaded, else the reset clears it
            cd_next = timeout_reg;
            if (sess_reg != SESS_IDLE) begin
                rst = 1'b1;
            end
        end else if (is_key) begin
            cd_next = timeout_reg;
            unique case (sess_reg)
                SESS_IDLE: begin
                    if (is_clr || is_ent) begin
                        rst = 1'b1;
                    end else begin
                        for (int i = 0; i < CODE_LEN; i++) begin
                            if (ecnt_reg == CNT_W'(i)) ent_next[DIGIT_W*i +: DIGIT_W] = key_reg;
                        end
                        ecnt_next = ecnt_reg + 1'b1;
                        sess_next = SESS_PASS;
                    end
                end
                SESS_PASS, SESS_ADMCHK, SESS_NEWADM, SESS_SLOTCODE: begin
                    if (is_clr || ecnt_reg > CNT_FULL) begin
                        if (sess_reg == SESS_ADMCHK && ecnt_reg == '0) begin
                            admin_next = admin_def;
                            written    = 1'b1;
                        end
                        rst = 1'b1;
                    end else if (is_ent) begin
                        case (sess_reg)
                            SESS_PASS: begin
                                if (ent_reg == admin_reg) begin
                                    clr       = 1'b1;
                                    sess_next = SESS_SLOTSEL;
                                end else begin
                                    unlock = match_reg;
                                    rst    = 1'b1;
                                end
                            end
                            SESS_ADMCHK: begin
                                if (ent_reg == admin_reg) begin
                                    def_all   = 1'b1;
                                    written   = 1'b1;
                                    clr       = 1'b1;
                                    sess_next = SESS_NEWADM;
                                end
                            end
                            SESS_NEWADM: begin
                                if (ecnt_reg == CNT_FULL) sess_next = SESS_ADMRPT;
                            end
                            default: begin
                                if (slot_reg < DIGIT_W'(NUM_SLOTS)) begin
                                    if (ecnt_reg == '0) slot_def = 1'b1;
                                    else                slot_wr  = 1'b1;
                                    written = 1'b1;
                                end
                                rst = 1'b1;
                            end
                        endcase
                    end else begin
                        for (int i = 0; i < CODE_LEN; i++) begin
                            if (ecnt_reg == CNT_W'(i)) ent_next[DIGIT_W*i +: DIGIT_W] = key_reg;
                        end
                        ecnt_next = ecnt_reg + 1'b1;
                    end
                end
                SESS_ADMRPT: begin
                    if (is_clr || rcnt_reg > CNT_FULL) begin
                        rst = 1'b1;
                    end else if (is_ent) begin
                        if (ent_reg == rpt_reg) begin
                            admin_next = ent_reg;
                            written    = 1'b1;
                        end
                        rst = 1'b1;
                    end else begin
                        for (int i = 0; i < CODE_LEN; i++) begin
                            if (rcnt_reg == CNT_W'(i)) rpt_next[DIGIT_W*i +: DIGIT_W] = key_reg;
                        end
                        rcnt_next = rcnt_reg + 1'b1;
                    end
                end
                SESS_SLOTSEL: begin
                    if (is_clr) begin
                        rst = 1'b1;
                    end else if (is_ent) begin
                        if (ecnt_reg == '0) begin
                            sess_next = SESS_CLRCONF;
                        end else begin
                            clr       = 1'b1;
                            sess_next = SESS_SLOTCODE;
                        end
                    end else begin
                        slot_next = key_reg;
                        ecnt_next = ecnt_reg + 1'b1;
                        if (ecnt_reg != '0) rst = 1'b1;
                    end
                end
                SESS_CLRCONF: begin
                    if (is_ent && ecnt_reg == '0) begin
                        def_all = 1'b1;
                        written = 1'b1;
                    end
                    rst = 1'b1;
                end
                default: begin
                    rst = 1'b1;
                end
            endcase
        end

        if (rst || clr) begin
            ent_next  = {CODE_LEN{BLANK}};
            rpt_next  = {CODE_LEN{BLANK}};
            ecnt_next = '0;
            rcnt_next = '0;
        end
        if (rst) begin
            slot_next = '0;
            sess_next = SESS_IDLE;
            cd_next   = '0;
        end
        if (is_prog) begin
            sess_next = SESS_ADMCHK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sess_reg     <= SESS_IDLE;
            ent_reg      <= {CODE_LEN{BLANK}};
            rpt_reg      <= {CODE_LEN{BLANK}};
            ecnt_reg     <= '0;
            rcnt_reg     <= '0;
            slot_reg     <= '0;
            admin_reg    <= admin_def;
            cd_reg       <= '0;
            slot_set_reg <= '0;
        end else if (cmd.commit) begin
            sess_reg  <= sess_next;
            ent_reg   <= ent_next;
            rpt_reg   <= rpt_next;
            ecnt_reg  <= ecnt_next;
            rcnt_reg  <= rcnt_next;
            slot_reg  <= slot_next;
            admin_reg <= admin_next;
            cd_reg    <= cd_next;
            for (int p = 0; p < NUM_SLOTS; p++) begin
                if (def_all) begin
                    slot_set_reg[p] <= 1'b0;
                end else if (slot_reg == DIGIT_W'(p)) begin
                    if (slot_def)     slot_set_reg[p] <= 1'b0;
                    else if (slot_wr) slot_set_reg[p] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int p = 0; p < NUM_SLOTS; p++) begin
            if (cmd.commit && slot_wr && slot_reg == DIGIT_W'(p)) begin
                slot_code_mem[p] <= ent_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_unlock        <= unlock;
            m_session_state <= sess_next;
            m_code_written  <= written;
            m_timed_out     <= timed;
        end
    end

`ifndef SYNTHESIS
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (sess_reg == SESS_IDLE) |-> (cd_reg == '0 && ecnt_reg == '0 && rcnt_reg == '0))
        else $error("idle session holds a countdown or entry digits");
`endif

endmodule

>>> src/keypad_lock_controller.sv
`timescale 1ns / 1ps
// Top level of the keypad combination lock session controller.
//
// Usage:
//   Input channel (s_valid/s_ready, s_mode, s_key): one word per key press
//   (s_mode 0, s_key 0-9 digit, 10 CLEAR, 11 ENTER, 12 PROGEN) or timer tick
//   (s_mode 1, s_key ignored). Keys 13-15 change nothing.
//   Result channel (m_valid/m_ready): exactly one word per input word, with
//   the unlock pulse, the session state after the step, a code-written flag
//   and a timeout flag.
//   Configuration: cfg_wr_en/cfg_wr_data load the 8-bit inactivity timeout
//   at once; write it only while no word is in flight.
// Sequence:
//   Each word is accepted, compared against every passcode slot in turn by
//   the sequential slot scan, then committed; commit waits while the output
//   register holds an untaken result. The slot scan sets the rate; one word
//   is worked at a time. Result valid rises the cycle after commit.
// Reset: synchronous active-low aresetn; session idle, buffers blank,
//   admin code 0,1,2,..., every slot back to its default, timeout 23.
// Stall: a finished result waits in the output register while the next word
//   is accepted and scanned; commit of that word holds until m_ready frees it.
module keypad_lock_controller
    import kpl_pkg::*;
#(
    parameter int CODE_LEN  = CODE_LEN_DEF,
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [TICKS_W-1:0] cfg_wr_data,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [DIGIT_W-1:0] s_key,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_unlock,
    output logic [2:0]         m_session_state,
    output logic               m_code_written,
    output logic               m_timed_out
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // sequencer: owns both handshakes
    kpl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // session machine, code storage, slot compare and result register
    kpl_dp #(
        .CODE_LEN  (CODE_LEN),
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_mode          (s_mode),
        .s_key           (s_key),
        .cmd             (cmd),
        .sts             (sts),
        .m_unlock        (m_unlock),
        .m_session_state (m_session_state),
        .m_code_written  (m_code_written),
        .m_timed_out     (m_timed_out)
    );

endmodule
